// File: rtl/core/ttb_pkg.sv
// Shared types and constants for the triangle tangent basis block.
package ttb_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_THIRD
    } phase_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL_A,
        BK_MUL_B,
        BK_DIFF,
        BK_DIV,
        BK_STORE,
        BK_EMIT
    } back_state_t;

    typedef enum logic [2:0] {
        OP_DET,
        OP_TAN_X,
        OP_TAN_Y,
        OP_TAN_Z,
        OP_BIT_X,
        OP_BIT_Y,
        OP_BIT_Z
    } op_t;

    localparam logic [1:0] SLOT_LAST = 2'd2;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// File: rtl/core/ttb_channels.sv
// Vertex and result channel interfaces.
interface ttb_vertex_if #(parameter int W = ttb_pkg::COORD_WIDTH_DEF);
    logic         valid;
    logic         ready;
    logic [W-1:0] pos_x;
    logic [W-1:0] pos_y;
    logic [W-1:0] pos_z;
    logic [W-1:0] tex_u;
    logic [W-1:0] tex_v;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttb_result_if #(parameter int W = ttb_pkg::COORD_WIDTH_DEF);
    logic         valid;
    logic         ready;
    logic [W-1:0] tangent_x;
    logic [W-1:0] tangent_y;
    logic [W-1:0] tangent_z;
    logic [W-1:0] bitangent_x;
    logic [W-1:0] bitangent_y;
    logic [W-1:0] bitangent_z;
    logic [1:0]   vertex_slot;
    logic         last_of_triangle;
    logic         degenerate;
    logic         overflow;

    modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
                    bitangent_z, vertex_slot, last_of_triangle, degenerate, overflow,
                    input ready);
    modport sink   (input valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
                    bitangent_z, vertex_slot, last_of_triangle, degenerate, overflow,
                    output ready);
endinterface

// File: rtl/core/triangle_tangent_basis_top.sv
// Triangle tangent basis: top level joining front end, job queue and back end.
//
// Input channel vtx carries one vertex per word (position x,y,z and texture
// u,v in signed fixed point). Every three accepted words form a triangle.
// Output channel res gives three words per triangle, vertex_slot 0, 1, 2,
// with last_of_triangle set on slot 2; all three carry the same tangent,
// bitangent, degenerate and overflow values.
// The front end takes the first two vertices at one per cycle and forms the
// edge deltas on the third; a two-entry queue holds finished triangles.
// The back end uses one multiplier and a bit-serial restoring divider:
// 2 products and a subtract for the determinant, then per component 2
// products, a subtract, 2*COORD_WIDTH+FRAC_BITS+3 divide steps and a store,
// and then the three output words. A zero determinant skips the divides.
// While the queue is full the third vertex of a triangle waits.
// A stalled res holds its word; the back end and then the queue back up.
// Reset clears the vertex phase, the queue and the back end sequencer.
module triangle_tangent_basis_top #(
    parameter int COORD_WIDTH = ttb_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ttb_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ttb_vertex_if.sink   vtx,
    ttb_result_if.source res
);
    import ttb_pkg::*;

    localparam int JW = 10 * (COORD_WIDTH + 1);

    logic          push, pop;
    logic [JW-1:0] push_job, pop_job;
    queue_status_t qstat;

    ttb_front #(.W(COORD_WIDTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .vtx      (vtx),
        .push     (push),
        .push_job (push_job),
        .qstat    (qstat)
    );

    ttb_queue #(.DW(JW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .pop_data  (pop_job),
        .stat      (qstat)
    );

    ttb_back #(.W(COORD_WIDTH), .F(FRAC_BITS)) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .job   (pop_job),
        .qstat (qstat),
        .pop   (pop),
        .res   (res)
    );

endmodule

// File: rtl/core/ttb_front.sv
// Front end: collects three vertices and forms the edge deltas of a triangle.
module ttb_front #(
    parameter int W = ttb_pkg::COORD_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    ttb_vertex_if.sink                vtx,
    output logic                      push,
    output logic [10*(W+1)-1:0]       push_job,
    input  ttb_pkg::queue_status_t    qstat
);
    import ttb_pkg::*;

    localparam int DW = W + 1;

    phase_t       phase_reg, phase_next;
    logic [W-1:0] p0x_reg, p0y_reg, p0z_reg, u0_reg, v0_reg;
    logic [W-1:0] p1x_reg, p1y_reg, p1z_reg, u1_reg, v1_reg;
    logic         accept;
    logic signed [DW-1:0] d [10];

    function automatic logic signed [W:0] delta(input logic [W-1:0] a, input logic [W-1:0] b);
        delta = $signed({a[W-1], a}) - $signed({b[W-1], b});
    endfunction

    assign vtx.ready = (phase_reg != PH_THIRD) || !qstat.full;
    assign accept    = vtx.valid && vtx.ready;
    assign push      = accept && (phase_reg == PH_THIRD);

    always_comb
    begin
        d[0] = delta(p1x_reg, p0x_reg);
        d[1] = delta(p1y_reg, p0y_reg);
        d[2] = delta(p1z_reg, p0z_reg);
        d[3] = delta(vtx.pos_x, p0x_reg);
        d[4] = delta(vtx.pos_y, p0y_reg);
        d[5] = delta(vtx.pos_z, p0z_reg);
        d[6] = delta(u1_reg, u0_reg);
        d[7] = delta(v1_reg, v0_reg);
        d[8] = delta(vtx.tex_u, u0_reg);
        d[9] = delta(vtx.tex_v, v0_reg);
        for (int k = 0; k < 10; k++)
        begin
            push_job[k*DW +: DW] = d[k];
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_SECOND: phase_next = PH_THIRD;
                PH_THIRD:  phase_next = PH_FIRST;
                default:   phase_next = PH_SECOND;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_FIRST;
        else
            phase_reg <= phase_next;
    end

    // hold vertex 0 and vertex 1
    always_ff @(posedge clk)
    begin
        if (accept && phase_reg == PH_SECOND)
        begin
            p1x_reg <= vtx.pos_x;
            p1y_reg <= vtx.pos_y;
            p1z_reg <= vtx.pos_z;
            u1_reg  <= vtx.tex_u;
            v1_reg  <= vtx.tex_v;
        end
        else if (accept && phase_reg != PH_THIRD)
        begin
            p0x_reg <= vtx.pos_x;
            p0y_reg <= vtx.pos_y;
            p0z_reg <= vtx.pos_z;
            u0_reg  <= vtx.tex_u;
            v0_reg  <= vtx.tex_v;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("triangle pushed into a full queue");
    a_push_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> phase_reg == PH_FIRST)
        else $error("phase did not wrap after a triangle");
    a_stall_third: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_THIRD && qstat.full) |-> !vtx.ready)
        else $error("third vertex taken while queue full");

endmodule

// File: rtl/core/ttb_queue.sv
// Two-entry queue of triangle jobs between front and back.
module ttb_queue #(
    parameter int DW = 330
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [DW-1:0]          push_data,
    input  logic                   pop,
    output logic [DW-1:0]          pop_data,
    output ttb_pkg::queue_status_t stat
);
    import ttb_pkg::*;

    logic [DW-1:0] entry_reg [2];
    logic          wptr_reg, rptr_reg;
    logic [1:0]    count_reg;

    assign pop_data   = entry_reg[rptr_reg];
    assign stat.full  = count_reg == 2'd2;
    assign stat.empty = count_reg == 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wptr_reg] <= push_data;
    end

endmodule

// File: rtl/core/ttb_back.sv
// Back end: products, determinant, serial division and the three result words.
module ttb_back #(
    parameter int W = ttb_pkg::COORD_WIDTH_DEF,
    parameter int F = ttb_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [10*(W+1)-1:0]    job,
    input  ttb_pkg::queue_status_t qstat,
    output logic                   pop,
    ttb_result_if.source           res
);
    import ttb_pkg::*;

    localparam int DW   = W + 1;
    localparam int PW   = 2 * DW;
    localparam int NW   = PW + 1;
    localparam int NUMW = NW + F;
    localparam int CW   = $clog2(NUMW + 1);

    back_state_t state_reg, state_next;
    op_t         op_reg;
    logic [10*DW-1:0]     job_reg;
    logic signed [DW-1:0] d [10];
    logic signed [DW-1:0] a1, b1, a2, b2, mx, my;
    logic signed [PW-1:0] prod, pa_reg, pb_reg;
    logic signed [NW-1:0] diff;
    logic [NW-1:0]        mag;
    logic [NW-1:0]        den_reg;
    logic                 den_neg_reg, neg_reg;
    logic [NW:0]          rem_reg, rem_sh;
    logic [NUMW-1:0]      dvd_reg, quo_reg, limit, qsat;
    logic [CW-1:0]        cnt_reg;
    logic [W-1:0]         vec_reg [6];
    logic [W-1:0]         comp;
    logic                 degen_reg, ovf_reg;
    logic [1:0]           slot_reg;

    always_comb
    begin
        for (int k = 0; k < 10; k++)
        begin
            d[k] = job_reg[k*DW +: DW];
        end
    end

    // operand pairs: 0..2 dP1, 3..5 dP2, 6 dU1, 7 dV1, 8 dU2, 9 dV2
    always_comb
    begin
        unique case (op_reg)
            OP_TAN_X: begin a1 = d[0]; b1 = d[9]; a2 = d[3]; b2 = d[7]; end
            OP_TAN_Y: begin a1 = d[1]; b1 = d[9]; a2 = d[4]; b2 = d[7]; end
            OP_TAN_Z: begin a1 = d[2]; b1 = d[9]; a2 = d[5]; b2 = d[7]; end
            OP_BIT_X: begin a1 = d[3]; b1 = d[6]; a2 = d[0]; b2 = d[8]; end
            OP_BIT_Y: begin a1 = d[4]; b1 = d[6]; a2 = d[1]; b2 = d[8]; end
            OP_BIT_Z: begin a1 = d[5]; b1 = d[6]; a2 = d[2]; b2 = d[8]; end
            default:  begin a1 = d[6]; b1 = d[9]; a2 = d[7]; b2 = d[8]; end
        endcase
    end

    assign mx   = (state_reg == BK_MUL_B) ? a2 : a1;
    assign my   = (state_reg == BK_MUL_B) ? b2 : b1;
    assign prod = mx * my;

    assign diff = $signed({pa_reg[PW-1], pa_reg}) - $signed({pb_reg[PW-1], pb_reg});
    assign mag  = diff[NW-1] ? NW'(-diff) : NW'(diff);

    assign rem_sh = {rem_reg[NW-1:0], dvd_reg[NUMW-1]};

    always_comb
    begin
        limit = {{(NUMW-W){1'b0}}, 1'b1, {(W-1){1'b0}}} - {{(NUMW-1){1'b0}}, !neg_reg};
        qsat  = (quo_reg > limit) ? limit : quo_reg;
        comp  = neg_reg ? W'(-qsat) : qsat[W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:  if (!qstat.empty) state_next = BK_MUL_A;
            BK_MUL_A: state_next = BK_MUL_B;
            BK_MUL_B: state_next = BK_DIFF;
            BK_DIFF:
            begin
                if (op_reg == OP_DET && mag == '0)
                    state_next = BK_EMIT;
                else if (op_reg == OP_DET)
                    state_next = BK_MUL_A;
                else
                    state_next = BK_DIV;
            end
            BK_DIV:   if (cnt_reg == CW'(1)) state_next = BK_STORE;
            BK_STORE: state_next = (op_reg == OP_BIT_Z) ? BK_EMIT : BK_MUL_A;
            BK_EMIT:  if (res.ready && slot_reg == SLOT_LAST) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        res.valid = 1'b0;
        unique case (state_reg)
            BK_IDLE: pop       = !qstat.empty;
            BK_EMIT: res.valid = 1'b1;
            default: ;
        endcase
    end

    assign res.tangent_x        = vec_reg[0];
    assign res.tangent_y        = vec_reg[1];
    assign res.tangent_z        = vec_reg[2];
    assign res.bitangent_x      = vec_reg[3];
    assign res.bitangent_y      = vec_reg[4];
    assign res.bitangent_z      = vec_reg[5];
    assign res.vertex_slot      = slot_reg;
    assign res.last_of_triangle = slot_reg == SLOT_LAST;
    assign res.degenerate       = degen_reg;
    assign res.overflow         = ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            op_reg    <= OP_DET;
            slot_reg  <= 2'd0;
            degen_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                BK_IDLE:
                begin
                    op_reg    <= OP_DET;
                    degen_reg <= 1'b0;
                    ovf_reg   <= 1'b0;
                end
                BK_DIFF:
                begin
                    if (op_reg == OP_DET)
                    begin
                        degen_reg <= mag == '0;
                        op_reg    <= OP_TAN_X;
                    end
                end
                BK_STORE:
                begin
                    if (quo_reg > limit)
                        ovf_reg <= 1'b1;
                    op_reg <= op_t'(op_reg + 3'd1);
                end
                BK_EMIT:
                begin
                    if (res.ready)
                        slot_reg <= (slot_reg == SLOT_LAST) ? 2'd0 : slot_reg + 2'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                if (!qstat.empty)
                    job_reg <= job;
            end
            BK_MUL_A: pa_reg <= prod;
            BK_MUL_B: pb_reg <= prod;
            BK_DIFF:
            begin
                if (op_reg == OP_DET)
                begin
                    den_reg     <= mag;
                    den_neg_reg <= diff[NW-1];
                    for (int k = 0; k < 6; k++)
                    begin
                        vec_reg[k] <= '0;
                    end
                end
                else
                begin
                    neg_reg <= diff[NW-1] ^ den_neg_reg;
                    dvd_reg <= {mag, {F{1'b0}}};
                    rem_reg <= '0;
                    quo_reg <= '0;
                    cnt_reg <= CW'(NUMW);
                end
            end
            BK_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, den_reg};
                    quo_reg <= {quo_reg[NUMW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[NUMW-2:0], 1'b0};
                end
                dvd_reg <= {dvd_reg[NUMW-2:0], 1'b0};
                cnt_reg <= cnt_reg - CW'(1);
            end
            BK_STORE:
            begin
                // shift components in so slot 0 ends up as tangent x
                for (int k = 0; k < 5; k++)
                begin
                    vec_reg[k] <= vec_reg[k+1];
                end
                vec_reg[5] <= comp;
            end
            default: ;
        endcase
    end

    a_degen_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.degenerate) |-> !res.overflow)
        else $error("degenerate triangle flagged overflow");
    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == BK_MUL_A && op_reg == OP_DET)
        else $error("job popped without starting the determinant");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.ready && res.last_of_triangle) |=> !res.valid)
        else $error("result word after last of triangle");
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> slot_reg != 2'd3)
        else $error("vertex slot out of range");

endmodule

// File: verif/triangle_tangent_basis_top_test.sv
// Stream test of triangle_tangent_basis_top: vertex triangles checked against a predictor.
module triangle_tangent_basis_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ttb_pkg::*;

    localparam int W          = COORD_WIDTH_DEF;
    localparam int FB         = FRAC_BITS_DEF;
    localparam int STALL_MAX  = 20000;
    localparam int TRI_RANDOM = 76;

    typedef struct {
        logic [W-1:0] px, py, pz, tu, tv;
        bit           drain;
    } vertex_t;

    typedef struct {
        logic [W-1:0] tan [3];
        logic [W-1:0] bit_v [3];
        logic [1:0]   slot;
        logic         last;
        logic         degen;
        logic         ovf;
    } basis_t;

    logic clk;
    logic rst_n;

    ttb_vertex_if #(W) vertex_bus ();
    ttb_result_if #(W) result_bus ();

    triangle_tangent_basis_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .vtx   (vertex_bus),
        .res   (result_bus)
    );

    vertex_t pending_vertices[$];
    basis_t  expected_basis[$];
    vertex_t cur_vertex;

    logic [W-1:0] held_pos[6];
    logic [W-1:0] held_tex[4];
    int           held_count;

    int errors;
    int vertices_sent;
    int results_seen;
    int degen_seen;
    int ovf_seen;
    int stall_cycles;
    bit quiet;

    always #5 clk = ~clk;

    // numerator * 2^FB / den, toward zero, saturated to W bits
    function automatic logic [W-1:0] scaled_quotient(input logic signed [127:0] num,
                                                     input logic signed [127:0] den,
                                                     inout logic ovf);
        logic [127:0] nmag;
        logic [127:0] dmag;
        logic [127:0] q;
        logic [127:0] lim;
        logic         neg;
        nmag = num < 0 ? -num : num;
        dmag = den < 0 ? -den : den;
        neg  = (num < 0) != (den < 0);
        q    = (nmag << FB) / dmag;
        lim  = neg ? (128'd1 << (W - 1)) : ((128'd1 << (W - 1)) - 1);
        if (q > lim)
        begin
            ovf = 1'b1;
            q   = lim;
        end
        if (neg)
            q = -q;
        return q[W-1:0];
    endfunction

    task automatic predict_basis(input vertex_t v);
        logic signed [127:0] dp1[3], dp2[3], du1, dv1, du2, dv2, det, p0;
        logic [W-1:0]        cur[3];
        basis_t              b;
        logic                ovf;
        cur[0] = v.px;
        cur[1] = v.py;
        cur[2] = v.pz;
        if (held_count == 0 || held_count == 1)
        begin
            for (int i = 0; i < 3; i++)
                held_pos[held_count * 3 + i] = cur[i];
            held_tex[held_count * 2]     = v.tu;
            held_tex[held_count * 2 + 1] = v.tv;
            held_count++;
            return;
        end
        held_count = 0;
        for (int i = 0; i < 3; i++)
        begin
            p0     = $signed(held_pos[i]);
            dp1[i] = $signed(held_pos[3 + i]) - p0;
            dp2[i] = $signed(cur[i]) - p0;
        end
        du1 = $signed(held_tex[2]) - $signed(held_tex[0]);
        dv1 = $signed(held_tex[3]) - $signed(held_tex[1]);
        du2 = $signed(v.tu) - $signed(held_tex[0]);
        dv2 = $signed(v.tv) - $signed(held_tex[1]);
        det = du1 * dv2 - dv1 * du2;
        ovf = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (det == 0)
            begin
                b.tan[i]   = '0;
                b.bit_v[i] = '0;
            end
            else
            begin
                b.tan[i]   = scaled_quotient(dp1[i] * dv2 - dp2[i] * dv1, det, ovf);
                b.bit_v[i] = scaled_quotient(dp2[i] * du1 - dp1[i] * du2, det, ovf);
            end
        end
        b.degen = det == 0;
        b.ovf   = ovf;
        for (int k = 0; k < 3; k++)
        begin
            b.slot = k[1:0];
            b.last = b.slot == SLOT_LAST;
            expected_basis = {expected_basis, b};
        end
    endtask

    // driver: one word per handshake, hold until accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_bus.valid <= 1'b0;
            vertex_bus.pos_x <= '0;
            vertex_bus.pos_y <= '0;
            vertex_bus.pos_z <= '0;
            vertex_bus.tex_u <= '0;
            vertex_bus.tex_v <= '0;
        end
        else
        begin
            if (vertex_bus.valid && vertex_bus.ready)
            begin
                predict_basis(cur_vertex);
                vertices_sent++;
            end
            if (!vertex_bus.valid || vertex_bus.ready)
            begin
                if (pending_vertices.size() > 0 && (quiet || $urandom_range(99) >= 6)
                    && !(pending_vertices[0].drain && expected_basis.size() != 0))
                begin
                    cur_vertex = pending_vertices.pop_front();
                    vertex_bus.valid <= 1'b1;
                    vertex_bus.pos_x <= cur_vertex.px;
                    vertex_bus.pos_y <= cur_vertex.py;
                    vertex_bus.pos_z <= cur_vertex.pz;
                    vertex_bus.tex_u <= cur_vertex.tu;
                    vertex_bus.tex_v <= cur_vertex.tv;
                end
                else
                    vertex_bus.valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [W-1:0] exp_v,
                               input logic [W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // monitor: compare every accepted result word with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        basis_t b;
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            stall_cycles = 0;
        end
        else
        begin
            result_bus.ready <= quiet || $urandom_range(99) >= 6;
            if ((vertex_bus.valid && vertex_bus.ready) || (result_bus.valid && result_bus.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (result_bus.valid && result_bus.ready)
            begin
                results_seen++;
                if (expected_basis.size() == 0)
                begin
                    $error("unexpected result word, slot %0d", result_bus.vertex_slot);
                    errors++;
                end
                else
                begin
                    b = expected_basis.pop_front();
                    if (b.degen)
                        degen_seen++;
                    if (b.ovf)
                        ovf_seen++;
                    check_field("tangent_x", b.tan[0], result_bus.tangent_x);
                    check_field("tangent_y", b.tan[1], result_bus.tangent_y);
                    check_field("tangent_z", b.tan[2], result_bus.tangent_z);
                    check_field("bitangent_x", b.bit_v[0], result_bus.bitangent_x);
                    check_field("bitangent_y", b.bit_v[1], result_bus.bitangent_y);
                    check_field("bitangent_z", b.bit_v[2], result_bus.bitangent_z);
                    check_field("vertex_slot", W'(b.slot), W'(result_bus.vertex_slot));
                    check_field("last_of_triangle", W'(b.last),
                                W'(result_bus.last_of_triangle));
                    check_field("degenerate", W'(b.degen), W'(result_bus.degenerate));
                    check_field("overflow", W'(b.ovf), W'(result_bus.overflow));
                end
            end
            if (stall_cycles >= STALL_MAX)
            begin
                $display("watchdog: no word moved for %0d cycles", STALL_MAX);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic add_vertex(input logic [W-1:0] px, py, pz, tu, tv, input bit drain = 0);
        vertex_t v;
        v.px    = px;
        v.py    = py;
        v.pz    = pz;
        v.tu    = tu;
        v.tv    = tv;
        v.drain = drain;
        pending_vertices = {pending_vertices, v};
    endtask

    function automatic logic [W-1:0] rand_coord(input int mode);
        logic [W-1:0] c;
        case (mode)
            0: c = $urandom;
            1: c = W'($signed(20'($urandom)));
            2: c = W'($signed(12'($urandom)));
            default:
            begin
                case ($urandom_range(4))
                    0: c = '0;
                    1: c = {1'b0, {(W-1){1'b1}}};
                    2: c = {1'b1, {(W-1){1'b0}}};
                    3: c = 1 << FB;
                    default: c = '1;
                endcase
            end
        endcase
        return c;
    endfunction

    initial
    begin
        logic [W-1:0] one, mx, mn;
        int           mode;
        clk          = 1'b0;
        rst_n        = 1'b0;
        errors       = 0;
        quiet        = 1'b0;
        held_count   = 0;
        for (int i = 0; i < 6; i++)
            held_pos[i] = '0;
        for (int i = 0; i < 4; i++)
            held_tex[i] = '0;
        one = 1 << FB;
        mx  = {1'b0, {(W-1){1'b1}}};
        mn  = {1'b1, {(W-1){1'b0}}};

        // all zero: degenerate
        repeat (3) add_vertex(0, 0, 0, 0, 0);
        // unit triangle, unit UV
        add_vertex(0, 0, 0, 0, 0);
        add_vertex(one, 0, 0, one, 0);
        add_vertex(0, one, 0, 0, one);
        // extreme positions over a tiny UV area: saturate
        add_vertex(mn, mn, mx, 0, 0);
        add_vertex(mx, mn, mn, 1, 0);
        add_vertex(mn, mx, mn, 0, 1);
        // negative determinant, saturate the other way
        add_vertex(mx, mx, mn, mx, mn);
        add_vertex(mn, mx, mx, mn, mn);
        add_vertex(mx, mn, mx, mx, mx, 1);
        // collinear UV, nonzero deltas: degenerate
        add_vertex(one, 2 * one, 3, one, one);
        add_vertex(-one, 5, 7, 2 * one, 2 * one);
        add_vertex(9, -3, one, 3 * one, 3 * one);
        // all ones and all min
        repeat (3) add_vertex('1, '1, '1, '1, '1);
        repeat (3) add_vertex(mn, mn, mn, mn, mn);

        for (int t = 0; t < TRI_RANDOM; t++)
        begin
            mode = $urandom_range(3);
            for (int k = 0; k < 3; k++)
                add_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                           rand_coord($urandom_range(3)), rand_coord(mode),
                           t == TRI_RANDOM / 2 && k == 0);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_vertices.size() > 0 || vertex_bus.valid)
        begin
            @(posedge clk);
            quiet <= vertices_sent >= 100 && vertices_sent < 180;
        end
        quiet <= 1'b0;
        while (expected_basis.size() > 0)
            @(posedge clk);
        repeat (600) @(posedge clk);

        $display("%0d vertices in, %0d result words out (%0d degenerate, %0d saturated)",
                 vertices_sent, results_seen, degen_seen, ovf_seen);
        if (errors == 0 && expected_basis.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
